FILE: rtl/smsp_pkg.sv
// smsp_pkg: constants, opcodes and shared types of the shuffled minimal
// standard generator. No dependencies.
`default_nettype none

package smsp_pkg;

   localparam int VALUE_WIDTH = 31;
   localparam int MUL_WIDTH   = 15;

   localparam logic [MUL_WIDTH-1:0]   LEHMER_MUL = 15'd16807;
   localparam logic [VALUE_WIDTH:0]   LEHMER_MOD = 32'd2147483647;

   localparam int TABLE_DEPTH_DEFAULT = 32;
   localparam int WARMUP_EXTRA        = 8;

   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   // request into the index unit
   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] value;
   } idx_req_type;

endpackage

`default_nettype wire

FILE: rtl/smsp_lehmer.sv
// smsp_lehmer: one Lehmer step x * 16807 mod (2^31 - 1), Mersenne fold.
// Depends on smsp_pkg.
`default_nettype none

module smsp_lehmer (
   input  wire logic [smsp_pkg::VALUE_WIDTH-1:0] x,
   output logic      [smsp_pkg::VALUE_WIDTH-1:0] y
);
   import smsp_pkg::*;

   localparam int PW = VALUE_WIDTH + MUL_WIDTH;

   logic [PW-1:0]          prod;
   logic [VALUE_WIDTH:0]   fold;

   // 2^31 == 1 mod M, so high part adds onto low part; one subtract suffices
   always_comb begin
      prod = PW'(x) * PW'(LEHMER_MUL);
      fold = {1'b0, prod[VALUE_WIDTH-1:0]} + (VALUE_WIDTH+1)'(prod[PW-1:VALUE_WIDTH]);
      if (fold >= LEHMER_MOD) begin
         fold = fold - LEHMER_MOD;
      end
      y = fold[VALUE_WIDTH-1:0];
   end

endmodule

`default_nettype wire

FILE: rtl/smsp_index.sv
// smsp_index: table index = value / NDIV, clamped, in three registered stages
// (reciprocal multiply, back multiply, one-step correction). Depends on smsp_pkg.
`default_nettype none

module smsp_index #(
   parameter int TABLE_DEPTH = smsp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire smsp_pkg::idx_req_type      req,
   output logic                            done,
   output logic [$clog2(TABLE_DEPTH)-1:0]  idx
);
   import smsp_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int QW = $clog2(TABLE_DEPTH) + 2;
   localparam int PW = VALUE_WIDTH + QW;
   localparam longint unsigned NDIV =
      64'd1 + (64'(LEHMER_MOD) - 64'd1) / 64'(TABLE_DEPTH);
   // floor(2^31 / NDIV): estimate is exact or one low
   localparam longint unsigned RCP = (64'd1 << VALUE_WIDTH) / NDIV;

   logic                   v1_ff, v2_ff, v3_ff;
   logic [VALUE_WIDTH-1:0] val1_ff, val2_ff, mul2_ff;
   logic [QW-1:0]          q1_ff, q2_ff;
   logic [IW-1:0]          idx_ff;

   logic [PW-1:0]          prod1, prod2;
   logic [QW-1:0]          q1_in, q_fix;
   logic [VALUE_WIDTH-1:0] mul2_in, rem;
   logic [IW-1:0]          idx_in;

   always_comb begin
      prod1   = PW'(req.value) * PW'(RCP);
      q1_in   = prod1[PW-1:VALUE_WIDTH];
      prod2   = PW'(q1_ff) * PW'(NDIV);
      mul2_in = prod2[VALUE_WIDTH-1:0];
      rem     = val2_ff - mul2_ff;
      q_fix   = (rem >= VALUE_WIDTH'(NDIV)) ? q2_ff + QW'(1) : q2_ff;
      if (q_fix >= QW'(TABLE_DEPTH)) begin
         idx_in = IW'(TABLE_DEPTH - 1);
      end else begin
         idx_in = q_fix[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         val1_ff <= req.value;
         q1_ff   <= q1_in;
      end
      if (v1_ff) begin
         val2_ff <= val1_ff;
         q2_ff   <= q1_ff;
         mul2_ff <= mul2_in;
      end
      if (v2_ff) begin
         idx_ff <= idx_in;
      end
   end

   assign done = v3_ff;
   assign idx  = idx_ff;

endmodule

`default_nettype wire

FILE: rtl/smsp_table.sv
// smsp_table: shuffle table, one write port and one read port, registered read.
// Depends on smsp_pkg.
`default_nettype none

module smsp_table #(
   parameter int TABLE_DEPTH = smsp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
   input  wire logic [smsp_pkg::VALUE_WIDTH-1:0]    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   output logic      [smsp_pkg::VALUE_WIDTH-1:0]    rd_data
);
   import smsp_pkg::*;

   logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/shuffled_minimal_standard_prng_unit.sv
// Shuffled minimal standard generator (Lehmer x*16807 mod 2^31-1, Bays-Durham).
// Plain draw: table read in ST_READ, result strobes in ST_EMIT, then ST_IDX
// waits for the divide unit to index the new output before the next accept.
// Reseed or first draw: D+8 warm-up steps, one per cycle, the last D through
// the table write port, then index and a plain draw. D = TABLE_DEPTH.
// Sync reset: generator = 1, shuffle output = 0 so the next draw initializes.
`default_nettype none

module shuffled_minimal_standard_prng_unit #(
   parameter int TABLE_DEPTH = smsp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_operation,
   input  wire logic [smsp_pkg::VALUE_WIDTH-1:0]  req_seed,
   output logic                                   rsp_strobe,
   output logic      [smsp_pkg::VALUE_WIDTH-1:0]  rsp_value
);
   import smsp_pkg::*;

   localparam int IW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
   localparam int CNT_TOP = TABLE_DEPTH + WARMUP_EXTRA - 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;  // warm-up and table fill
   localparam logic [2:0] ST_IDX  = 3'd2;  // wait for index of shuffle output
   localparam logic [2:0] ST_READ = 3'd3;  // table read, generator advance
   localparam logic [2:0] ST_EMIT = 3'd4;  // read data out, swap in new value

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] gen_ff, gen_in;
   logic [VALUE_WIDTH-1:0] shuf_ff, shuf_in;
   logic                   pend_ff, pend_in;   // a draw still owed for this item

   logic [VALUE_WIDTH-1:0] gen_next;
   idx_req_type            idx_req;
   logic                   idx_done;
   logic [IW-1:0]          idx;

   logic                   wr_en, rd_en;
   logic [IW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data;
   logic                   accept;

   smsp_lehmer u_lehmer (
      .x (gen_ff),
      .y (gen_next)
   );

   smsp_index #(.TABLE_DEPTH(TABLE_DEPTH)) u_index (
      .clock (clock),
      .reset (reset),
      .req   (idx_req),
      .done  (idx_done),
      .idx   (idx)
   );

   // Read happens in ST_READ, write back to the same entry in ST_EMIT, so the
   // two never overlap and no forwarding is needed.
   smsp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      gen_in        = gen_ff;
      shuf_in       = shuf_ff;
      pend_in       = pend_ff;
      idx_req.start = 1'b0;
      idx_req.value = gen_next;
      wr_en         = 1'b0;
      wr_addr       = idx;
      wr_data       = gen_ff;
      rd_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in = 1'b1;
               cnt_in  = CW'(CNT_TOP);
               if (req_operation == OP_RESEED) begin
                  // seed zero is forced to one
                  gen_in   = (req_seed == '0) ? VALUE_WIDTH'(1) : req_seed;
                  state_in = ST_INIT;
               end else if (shuf_ff == '0 || gen_ff == '0) begin
                  // uninitialized (or collapsed) state restarts from one
                  gen_in   = VALUE_WIDTH'(1);
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_INIT: begin
            gen_in = gen_next;
            if (cnt_ff < CW'(TABLE_DEPTH)) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[IW-1:0];
               wr_data = gen_next;
            end
            if (cnt_ff == '0) begin
               // entry 0 is the last value written: shuffle output without a read
               shuf_in       = gen_next;
               idx_req.start = 1'b1;
               idx_req.value = gen_next;
               state_in      = ST_IDX;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_IDX: begin
            if (idx_done) begin
               state_in = pend_ff ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            gen_in   = gen_next;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            wr_en         = 1'b1;
            wr_addr       = idx;
            wr_data       = gen_ff;
            shuf_in       = rd_data;
            idx_req.start = 1'b1;
            idx_req.value = rd_data;
            pend_in       = 1'b0;
            state_in      = ST_IDX;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         gen_ff   <= VALUE_WIDTH'(1);
         shuf_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         gen_ff   <= gen_in;
         shuf_ff  <= shuf_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   assign rsp_strobe = (state_ff == ST_EMIT);
   assign rsp_value  = rd_data;

endmodule

`default_nettype wire

FILE: rtl/smsp_checker.sv
// smsp_checker: port-level assertions for the generator top level, plus bind.
// Depends on smsp_pkg and shuffled_minimal_standard_prng_unit.
`default_nettype none

module smsp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_strobe,
   input wire logic [smsp_pkg::VALUE_WIDTH-1:0]  rsp_value
);
   import smsp_pkg::*;

   // each item yields exactly one result, followed by index work
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result strobes in a row");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make block busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // value range of a strobed result
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_value} != LEHMER_MOD))
      else $error("result equals modulus");

endmodule

bind shuffled_minimal_standard_prng_unit smsp_checker u_smsp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_value  (rsp_value)
);

`default_nettype wire
